>>> hdl/pvp_pkg.sv
// Shared types and constants for the perspective vertex projector.
`default_nettype none
package pvp_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_CAMERA_X     = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y     = 3'd1;
  localparam logic [2:0] CFG_CAMERA_Z     = 3'd2;
  localparam logic [2:0] CFG_YAW_COSINE   = 3'd3;
  localparam logic [2:0] CFG_YAW_SINE     = 3'd4;
  localparam logic [2:0] CFG_PITCH_COSINE = 3'd5;
  localparam logic [2:0] CFG_PITCH_SINE   = 3'd6;

  // Reset values of the configuration registers
  localparam logic signed [15:0] RST_CAMERA_X     = 16'sd3379;
  localparam logic signed [15:0] RST_CAMERA_Y     = 16'sd4608;
  localparam logic signed [15:0] RST_CAMERA_Z     = -16'sd4301;
  localparam logic signed [15:0] RST_YAW_COSINE   = 16'sd12943;
  localparam logic signed [15:0] RST_YAW_SINE     = -16'sd10045;
  localparam logic signed [15:0] RST_PITCH_COSINE = 16'sd12209;
  localparam logic signed [15:0] RST_PITCH_SINE   = -16'sd10926;

  // Projection scale and divider geometry
  localparam logic signed [9:0] PROJ_SCALE = 10'sd200;
  localparam int unsigned QBITS = 19;   // quotient bits, 18 down to 0
  localparam int unsigned DENW  = 51;   // rotated depth width
  localparam int unsigned REMW  = 70;   // DENW + QBITS

  typedef struct packed {
    logic signed [15:0] camera_x;
    logic signed [15:0] camera_y;
    logic signed [15:0] camera_z;
    logic signed [15:0] yaw_cosine;
    logic signed [15:0] yaw_sine;
    logic signed [15:0] pitch_cosine;
    logic signed [15:0] pitch_sine;
  } pvp_cfg_t;

  // State of one item inside the divider pipeline
  typedef struct packed {
    logic [REMW-1:0]  rem_x;
    logic [REMW-1:0]  rem_y;
    logic [DENW-1:0]  den;
    logic [QBITS-1:0] quo_x;
    logic [QBITS-1:0] quo_y;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             behind;
    logic             last;
  } pvp_div_t;

endpackage
`default_nettype wire

>>> hdl/pvp_front.sv
// Front pipeline: camera offset, yaw and pitch rotation, numerators and range check.
`default_nettype none
module pvp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pvp_pkg::pvp_cfg_t  cfg_i,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic signed [15:0] vertex_x_i,
  input  wire logic signed [15:0] vertex_y_i,
  input  wire logic signed [15:0] vertex_z_i,
  input  wire logic               last_vertex_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output pvp_pkg::pvp_div_t       data_o
);
  import pvp_pkg::*;

  logic [7:1] v_q;
  logic [7:1] vin;
  logic [8:1] ld;
  logic [6:1] last_q;

  // Stage 1: offsets
  logic signed [16:0] dx_q, dy_q, dz_q;
  // Stage 2: yaw products
  logic signed [32:0] pxc_q, pzs_q, pzc_q, pxs_q;
  logic signed [16:0] dy2_q;
  // Stage 3: yaw sums
  logic signed [33:0] x1_q, z1_q;
  logic signed [30:0] dys_q;
  // Stage 4: pitch products
  logic signed [46:0] pyc_q, pys_q;
  logic signed [49:0] pzs2_q, pzc2_q;
  logic signed [33:0] x1b_q;
  // Stage 5: pitch sums
  logic signed [50:0] y2_q, z2_q;
  logic signed [33:0] x1c_q;
  // Stage 6: numerator magnitudes
  logic signed [55:0] nx_d;
  logic signed [58:0] ny_d;
  logic signed [REMW-1:0] nxw, nyw;
  logic [REMW-1:0] magx_q, magy_q;
  logic negx_q, negy_q, behind_q;
  logic [DENW-1:0] den_q;
  // Stage 7: range check
  pvp_div_t out_q;
  logic [REMW-1:0] den_lim;

  // Collapse bubbles: a stage loads when empty or when the next one moves
  assign vin   = {v_q[6:1], valid_i};
  always_comb begin
    ld[8] = ready_i;
    for (int k = 7; k >= 1; k--) begin
      ld[k] = ~v_q[k] | ld[k+1];
    end
  end
  assign ready_o = ld[1];
  assign valid_o = v_q[7];
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= 7; k++) begin
        if (ld[k]) v_q[k] <= vin[k];
      end
    end
  end

  // Advance the frame marker with the data
  always_ff @(posedge clk_i) begin
    if (ld[1]) last_q[1] <= last_vertex_i;
    for (int k = 2; k <= 6; k++) begin
      if (ld[k]) last_q[k] <= last_q[k-1];
    end
  end

  // Numerators and depth checks
  assign nx_d    = (56'(x1c_q) * PROJ_SCALE) <<< 14;
  assign ny_d    = 59'(y2_q) * PROJ_SCALE;
  assign nxw     = REMW'(nx_d);
  assign nyw     = REMW'(ny_d);
  assign den_lim = REMW'(den_q) << QBITS;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      dx_q <= 17'(vertex_x_i) - 17'(cfg_i.camera_x);
      dy_q <= 17'(vertex_y_i) - 17'(cfg_i.camera_y);
      dz_q <= 17'(vertex_z_i) - 17'(cfg_i.camera_z);
    end
    if (ld[2]) begin
      pxc_q <= dx_q * cfg_i.yaw_cosine;
      pzs_q <= dz_q * cfg_i.yaw_sine;
      pzc_q <= dz_q * cfg_i.yaw_cosine;
      pxs_q <= dx_q * cfg_i.yaw_sine;
      dy2_q <= dy_q;
    end
    if (ld[3]) begin
      x1_q  <= 34'(pxc_q) - 34'(pzs_q);
      z1_q  <= 34'(pzc_q) + 34'(pxs_q);
      dys_q <= 31'(dy2_q) <<< 14;
    end
    if (ld[4]) begin
      pyc_q  <= dys_q * cfg_i.pitch_cosine;
      pys_q  <= dys_q * cfg_i.pitch_sine;
      pzs2_q <= z1_q * cfg_i.pitch_sine;
      pzc2_q <= z1_q * cfg_i.pitch_cosine;
      x1b_q  <= x1_q;
    end
    if (ld[5]) begin
      y2_q  <= 51'(pyc_q) - 51'(pzs2_q);
      z2_q  <= 51'(pzc2_q) + 51'(pys_q);
      x1c_q <= x1b_q;
    end
    if (ld[6]) begin
      negx_q   <= nx_d[55];
      negy_q   <= ny_d[58];
      magx_q   <= nx_d[55] ? REMW'(-nxw) : REMW'(nxw);
      magy_q   <= ny_d[58] ? REMW'(-nyw) : REMW'(nyw);
      behind_q <= z2_q[50] | (z2_q == '0);
      den_q    <= DENW'(z2_q);
    end
    if (ld[7]) begin
      out_q.rem_x  <= magx_q;
      out_q.rem_y  <= magy_q;
      out_q.den    <= den_q;
      out_q.quo_x  <= '0;
      out_q.quo_y  <= '0;
      out_q.neg_x  <= negx_q;
      out_q.neg_y  <= negy_q;
      out_q.ovf_x  <= magx_q >= den_lim;
      out_q.ovf_y  <= magy_q >= den_lim;
      out_q.behind <= behind_q;
      out_q.last   <= last_q[6];
    end
  end

endmodule
`default_nettype wire

>>> hdl/pvp_div_stage.sv
// One restoring-division step for both screen axes, with its own pipeline register.
`default_nettype none
module pvp_div_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire pvp_pkg::pvp_div_t data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output pvp_pkg::pvp_div_t      data_o
);
  import pvp_pkg::*;

  logic            v_q;
  pvp_div_t        d_q;
  pvp_div_t        step;
  logic [REMW-1:0] dsh;

  assign ready_o = ~v_q | ready_i;
  assign valid_o = v_q;
  assign data_o  = d_q;
  assign dsh     = REMW'(data_i.den) << SHIFT;

  // Subtract the shifted divisor where it fits and set the quotient bit
  always_comb begin
    step = data_i;
    if (data_i.rem_x >= dsh) begin
      step.rem_x        = data_i.rem_x - dsh;
      step.quo_x[SHIFT] = 1'b1;
    end
    if (data_i.rem_y >= dsh) begin
      step.rem_y        = data_i.rem_y - dsh;
      step.quo_y[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) d_q <= step;
  end

endmodule
`default_nettype wire

>>> hdl/perspective_vertex_projector_core.sv
// Top level: configuration registers, projection pipeline, output saturation.
//
// Usage: vertices enter on the in channel (valid/ready), one transaction per
// vertex in signed Q6.10. Each produces one transaction on the out channel
// with screen_x, screen_y (signed, saturated to 16 bits), behind_camera and
// frame_end (copy of last_vertex). The config channel writes one of seven
// registers (camera position, yaw and pitch cosine/sine); it is always ready
// and writes to an unknown index are dropped. Write it only when idle.
// Pipeline from input to output transaction: 7 front stages
// (offset, yaw multiply, yaw sum, pitch multiply, pitch sum, numerator,
// range check), 19 divider stages of one quotient bit each, and the output
// register. Throughput: one vertex per cycle unless stalled, set by the
// fully pipelined divider. Every stage loads when empty or when its
// successor moves, so bubbles collapse and the input keeps accepting while
// a result waits. When the receiver stalls, the pipeline fills and in_ready_o
// drops once all stages hold a vertex; nothing is lost or repeated.
// Reset: all stages empty, registers return to their default camera.
`default_nettype none
module perspective_vertex_projector_core #(
  parameter int unsigned SCREEN_CENTER_X = 160,
  parameter int unsigned SCREEN_CENTER_Y = 120
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] vertex_x_i,
  input  wire logic signed [15:0] vertex_y_i,
  input  wire logic signed [15:0] vertex_z_i,
  input  wire logic               last_vertex_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      screen_x_o,
  output logic signed [15:0]      screen_y_o,
  output logic                    behind_camera_o,
  output logic                    frame_end_o
);
  import pvp_pkg::*;

  localparam logic signed [20:0] CX = 21'(SCREEN_CENTER_X);
  localparam logic signed [20:0] CY = 21'(SCREEN_CENTER_Y);

  pvp_cfg_t cfg_q;
  pvp_div_t dd [0:QBITS];
  logic     dv [0:QBITS];
  logic     dr [0:QBITS];

  logic               ov_q;
  logic               ld_out;
  logic [QBITS-1:0]   mag_x, mag_y;
  logic signed [20:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y;
  logic signed [15:0] sx_q, sy_q;
  logic               behind_q, fend_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x     <= RST_CAMERA_X;
      cfg_q.camera_y     <= RST_CAMERA_Y;
      cfg_q.camera_z     <= RST_CAMERA_Z;
      cfg_q.yaw_cosine   <= RST_YAW_COSINE;
      cfg_q.yaw_sine     <= RST_YAW_SINE;
      cfg_q.pitch_cosine <= RST_PITCH_COSINE;
      cfg_q.pitch_sine   <= RST_PITCH_SINE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CAMERA_X:     cfg_q.camera_x     <= cfg_data_i;
        CFG_CAMERA_Y:     cfg_q.camera_y     <= cfg_data_i;
        CFG_CAMERA_Z:     cfg_q.camera_z     <= cfg_data_i;
        CFG_YAW_COSINE:   cfg_q.yaw_cosine   <= cfg_data_i;
        CFG_YAW_SINE:     cfg_q.yaw_sine     <= cfg_data_i;
        CFG_PITCH_COSINE: cfg_q.pitch_cosine <= cfg_data_i;
        CFG_PITCH_SINE:   cfg_q.pitch_sine   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Rotation and numerator stages
  pvp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .vertex_z_i    (vertex_z_i),
    .last_vertex_i (last_vertex_i),
    .valid_o       (dv[0]),
    .ready_i       (dr[0]),
    .data_o        (dd[0])
  );

  // Divider: one quotient bit per stage, most significant first
  for (genvar i = 0; i < QBITS; i++) begin : g_div
    pvp_div_stage #(
      .SHIFT (QBITS - 1 - i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[i]),
      .ready_o (dr[i]),
      .data_i  (dd[i]),
      .valid_o (dv[i+1]),
      .ready_i (dr[i+1]),
      .data_o  (dd[i+1])
    );
  end

  // Clamp, apply sign and center, saturate
  assign mag_x = dd[QBITS].ovf_x ? '1 : dd[QBITS].quo_x;
  assign mag_y = dd[QBITS].ovf_y ? '1 : dd[QBITS].quo_y;
  assign sum_x = dd[QBITS].neg_x ? CX - 21'(mag_x) : CX + 21'(mag_x);
  assign sum_y = dd[QBITS].neg_y ? CY + 21'(mag_y) : CY - 21'(mag_y);

  always_comb begin
    if (sum_x > 21'sd32767)       sat_x = 16'sh7fff;
    else if (sum_x < -21'sd32768) sat_x = -16'sh8000;
    else                          sat_x = 16'(sum_x);
    if (sum_y > 21'sd32767)       sat_y = 16'sh7fff;
    else if (sum_y < -21'sd32768) sat_y = -16'sh8000;
    else                          sat_y = 16'(sum_y);
  end

  // Output register
  assign ld_out    = ~ov_q | out_ready_i;
  assign dr[QBITS] = ld_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ld_out) begin
      ov_q <= dv[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      sx_q     <= dd[QBITS].behind ? '0 : sat_x;
      sy_q     <= dd[QBITS].behind ? '0 : sat_y;
      behind_q <= dd[QBITS].behind;
      fend_q   <= dd[QBITS].last;
    end
  end

  assign out_valid_o     = ov_q;
  assign screen_x_o      = sx_q;
  assign screen_y_o      = sy_q;
  assign behind_camera_o = behind_q;
  assign frame_end_o     = fend_q;

`ifndef SYNTHESIS
  // A vertex behind the camera reports the origin
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && behind_camera_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("behind-camera result with nonzero coordinates");

  // Input backpressure only arises when a result is held at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // A held result with a stalled receiver keeps the pipeline from dropping it
  a_hold_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(screen_x_o)
      && $stable(screen_y_o)))
    else $error("held result changed under stall");
`endif

endmodule
`default_nettype wire
